[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

// Condition that holds at every edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion lbl failed");

`endif

[design/ttpd_pkg.sv]
// ----------------------------------------------------------------------------
// Tag tracking PD controller package
// Fixed-point constants, register indexes, item types and control structs.
// ----------------------------------------------------------------------------
package ttpd_pkg;

  localparam int POS_FRAC_BITS  = 16;
  localparam int GAIN_FRAC_BITS = 12;

  localparam int GainOne = 1 << GAIN_FRAC_BITS;
  localparam int PosOne  = 1 << POS_FRAC_BITS;

  localparam logic [15:0]        KpXyRst     = 16'((48 * GainOne + 50) / 100);
  localparam logic [15:0]        KdXyRst     = 16'((10 * GainOne + 50) / 100);
  localparam logic [15:0]        KpZRst      = 16'((48 * GainOne + 500) / 1000);
  localparam logic [15:0]        KdZRst      = 16'((GainOne + 50) / 100);
  localparam logic signed [31:0] HoverAltRst = -32'sd1 * 32'(PosOne / 2);
  localparam logic [15:0]        TagTolRst   = 16'((PosOne + 5000) / 10000);
  localparam logic [9:0]         LoopRateRst = 10'd20;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgKpXy     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKdXy     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKpZ      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKdZ      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHoverAlt = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTagTol   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgLoopRate = 3'd6;

  localparam int          NumAxes = 3;
  localparam int          AxisW   = 2;
  localparam logic [AxisW-1:0] AxisX = 2'd0;
  localparam logic [AxisW-1:0] AxisZ = 2'd2;

  typedef struct packed {
    logic signed [31:0] tag_x;
    logic signed [31:0] tag_y;
    logic signed [31:0] tag_z;
    logic               tag_seen;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic signed [31:0] set_x;
    logic signed [31:0] set_y;
    logic signed [31:0] set_z;
  } out_item_t;

  typedef enum logic [1:0] {
    MulKdRate,
    MulKpErr,
    MulDerr,
    MulVelRate
  } mul_sel_e;

  typedef struct packed {
    logic             capture_in;
    logic             capture_tag;
    logic             track_tag;
    logic             load_err;
    logic             mul_en;
    mul_sel_e         mul_sel;
    logic             wr_kr;
    logic             wr_vel;
    logic             wr_acc;
    logic             wr_set;
    logic             save_prev;
    logic             load_out;
    logic [AxisW-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic tag_seen;
  } status_t;

endpackage

[design/ttpd_stream_if.sv]
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface ttpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/ttpd_ctrl.sv]
// ----------------------------------------------------------------------------
// Tag tracking PD controller sequencer
// Mode tracking, per-axis multiply schedule and output handshake.
// ----------------------------------------------------------------------------
module ttpd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ttpd_pkg::status_t status_i,
  output ttpd_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_ERR,
    S_KR,
    S_KP,
    S_DRV,
    S_RAT,
    S_SET,
    S_DONE
  } state_e;

  state_e                     state_q;
  logic [ttpd_pkg::AxisW-1:0] axis_q;
  logic                       landing_q;
  logic                       out_valid_q;
  logic                       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.mul_sel    = ttpd_pkg::MulKdRate;
    cmd_o.axis       = axis_q;
    cmd_o.capture_in = in_valid_i && in_ready_o;
    case (state_q)
      S_EVAL: begin
        cmd_o.capture_tag = !landing_q && status_i.tag_seen;
        cmd_o.track_tag   = landing_q;
      end
      S_ERR: cmd_o.load_err = 1'b1;
      S_KR: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = ttpd_pkg::MulKdRate;
      end
      S_KP: begin
        cmd_o.wr_kr   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = ttpd_pkg::MulKpErr;
      end
      S_DRV: begin
        cmd_o.wr_vel  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = ttpd_pkg::MulDerr;
      end
      S_RAT: begin
        cmd_o.wr_acc  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = ttpd_pkg::MulVelRate;
      end
      S_SET: cmd_o.wr_set = 1'b1;
      S_DONE: begin
        cmd_o.load_out  = out_free;
        cmd_o.save_prev = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= ttpd_pkg::AxisX;
      landing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (landing_q) begin
            state_q <= S_ERR;
          end else begin
            if (status_i.tag_seen) landing_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_ERR: begin
          axis_q  <= ttpd_pkg::AxisX;
          state_q <= S_KR;
        end
        S_KR:  state_q <= S_KP;
        S_KP:  state_q <= S_DRV;
        S_DRV: state_q <= S_RAT;
        S_RAT: state_q <= S_SET;
        S_SET: begin
          if (axis_q == ttpd_pkg::AxisZ) begin
            state_q <= S_DONE;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= S_KR;
          end
        end
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[design/ttpd_datapath.sv]
// ----------------------------------------------------------------------------
// Tag tracking PD controller datapath
// Config registers, tag estimate, errors, shared multiplier and result regs.
// ----------------------------------------------------------------------------
module ttpd_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ttpd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ttpd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  ttpd_pkg::in_item_t              in_item_i,
  output ttpd_pkg::out_item_t             out_item_o,
  input  ttpd_pkg::cmd_t                  cmd_i,
  output ttpd_pkg::status_t               status_o
);

  localparam logic signed [60:0] SatHi   = 61'sd2147483647;
  localparam logic signed [60:0] SatLo   = -61'sd2147483648;
  localparam logic signed [60:0] HalfLsb = 61'sd1 <<< (ttpd_pkg::GAIN_FRAC_BITS - 1);

  function automatic logic signed [31:0] sat32(input logic signed [60:0] x);
    logic signed [31:0] r;
    if (x > SatHi) begin
      r = 32'sh7fff_ffff;
    end else if (x < SatLo) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  logic [15:0]        kp_xy_q, kd_xy_q, kp_z_q, kd_z_q, tag_tol_q;
  logic signed [31:0] hover_alt_q;
  logic [9:0]         loop_rate_q;

  logic signed [31:0] tag_q  [ttpd_pkg::NumAxes];
  logic signed [31:0] cur_q  [ttpd_pkg::NumAxes];
  logic               seen_q;
  logic signed [31:0] est_q  [ttpd_pkg::NumAxes];
  logic signed [31:0] prev_q [ttpd_pkg::NumAxes];
  logic signed [31:0] err_q  [ttpd_pkg::NumAxes];
  logic signed [31:0] vel_q  [ttpd_pkg::NumAxes];
  logic signed [31:0] acc_q  [ttpd_pkg::NumAxes];
  logic signed [31:0] set_q  [ttpd_pkg::NumAxes];
  logic [25:0]        kr_q;
  logic signed [59:0] prod_q;
  ttpd_pkg::out_item_t out_q;

  logic [ttpd_pkg::NumAxes-1:0] moved;
  logic                         any_moved;
  logic signed [32:0]           tag_diff [ttpd_pkg::NumAxes];
  logic [32:0]                  tag_abs  [ttpd_pkg::NumAxes];

  logic signed [32:0] op_a;
  logic signed [26:0] op_b;
  logic signed [59:0] prod_d;
  logic signed [60:0] rnd_sum;
  logic signed [60:0] rnd_val;
  logic signed [60:0] set_sum;
  logic [15:0]        kp_sel, kd_sel;

  assign status_o.tag_seen = seen_q;
  assign out_item_o        = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_xy_q     <= ttpd_pkg::KpXyRst;
      kd_xy_q     <= ttpd_pkg::KdXyRst;
      kp_z_q      <= ttpd_pkg::KpZRst;
      kd_z_q      <= ttpd_pkg::KdZRst;
      hover_alt_q <= ttpd_pkg::HoverAltRst;
      tag_tol_q   <= ttpd_pkg::TagTolRst;
      loop_rate_q <= ttpd_pkg::LoopRateRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ttpd_pkg::CfgKpXy:     kp_xy_q     <= cfg_data_i[15:0];
        ttpd_pkg::CfgKdXy:     kd_xy_q     <= cfg_data_i[15:0];
        ttpd_pkg::CfgKpZ:      kp_z_q      <= cfg_data_i[15:0];
        ttpd_pkg::CfgKdZ:      kd_z_q      <= cfg_data_i[15:0];
        ttpd_pkg::CfgHoverAlt: hover_alt_q <= cfg_data_i[31:0];
        ttpd_pkg::CfgTagTol:   tag_tol_q   <= cfg_data_i[15:0];
        ttpd_pkg::CfgLoopRate: loop_rate_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Tag refresh test: any axis off by at least the tolerance.
  always_comb begin
    for (int i = 0; i < ttpd_pkg::NumAxes; i++) begin
      tag_diff[i] = {tag_q[i][31], tag_q[i]} - {est_q[i][31], est_q[i]};
      tag_abs[i]  = tag_diff[i][32] ? 33'(-tag_diff[i]) : 33'(tag_diff[i]);
      moved[i]    = tag_abs[i] >= {17'd0, tag_tol_q};
    end
  end
  assign any_moved = |moved;

  assign kp_sel = (cmd_i.axis == ttpd_pkg::AxisZ) ? kp_z_q : kp_xy_q;
  assign kd_sel = (cmd_i.axis == ttpd_pkg::AxisZ) ? kd_z_q : kd_xy_q;

  // Shared multiplier; kd*rate is formed first so the error difference
  // sees a single 33x27 product.
  always_comb begin
    case (cmd_i.mul_sel)
      ttpd_pkg::MulKdRate: begin
        op_a = $signed({17'd0, kd_sel});
        op_b = $signed({17'd0, loop_rate_q});
      end
      ttpd_pkg::MulKpErr: begin
        op_a = {err_q[cmd_i.axis][31], err_q[cmd_i.axis]};
        op_b = $signed({11'd0, kp_sel});
      end
      ttpd_pkg::MulDerr: begin
        op_a = {err_q[cmd_i.axis][31], err_q[cmd_i.axis]}
             - {prev_q[cmd_i.axis][31], prev_q[cmd_i.axis]};
        op_b = $signed({1'b0, kr_q});
      end
      ttpd_pkg::MulVelRate: begin
        op_a = {vel_q[cmd_i.axis][31], vel_q[cmd_i.axis]};
        op_b = $signed({17'd0, loop_rate_q});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod_d = op_a * op_b;
  end

  // Round to nearest, ties up, then drop the gain fraction.
  assign rnd_sum = {prod_q[59], prod_q} + HalfLsb;
  assign rnd_val = rnd_sum >>> ttpd_pkg::GAIN_FRAC_BITS;
  assign set_sum = {{29{cur_q[cmd_i.axis][31]}}, cur_q[cmd_i.axis]}
                 + {prod_q[59], prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ttpd_pkg::NumAxes; i++) begin
        est_q[i]  <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      if (cmd_i.capture_tag || (cmd_i.track_tag && any_moved)) begin
        for (int i = 0; i < ttpd_pkg::NumAxes; i++) est_q[i] <= tag_q[i];
      end
      if (cmd_i.save_prev) begin
        for (int i = 0; i < ttpd_pkg::NumAxes; i++) prev_q[i] <= err_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_in) begin
      tag_q[0] <= in_item_i.tag_x;
      tag_q[1] <= in_item_i.tag_y;
      tag_q[2] <= in_item_i.tag_z;
      cur_q[0] <= in_item_i.cur_x;
      cur_q[1] <= in_item_i.cur_y;
      cur_q[2] <= in_item_i.cur_z;
      seen_q   <= in_item_i.tag_seen;
    end
    if (cmd_i.load_err) begin
      err_q[0] <= sat32(61'(est_q[0]) - 61'(cur_q[0]));
      err_q[1] <= sat32(61'(est_q[1]) - 61'(cur_q[1]));
      err_q[2] <= sat32(61'(hover_alt_q) - 61'(cur_q[2]));
    end
    if (cmd_i.mul_en) prod_q <= prod_d;
    if (cmd_i.wr_kr)  kr_q <= prod_q[25:0];
    if (cmd_i.wr_vel) vel_q[cmd_i.axis] <= sat32(rnd_val);
    if (cmd_i.wr_acc) acc_q[cmd_i.axis] <= sat32(rnd_val);
    if (cmd_i.wr_set) set_q[cmd_i.axis] <= sat32(set_sum);
    if (cmd_i.load_out) begin
      out_q.vel_x <= vel_q[0];
      out_q.vel_y <= vel_q[1];
      out_q.vel_z <= vel_q[2];
      out_q.acc_x <= acc_q[0];
      out_q.acc_y <= acc_q[1];
      out_q.acc_z <= acc_q[2];
      out_q.set_x <= set_q[0];
      out_q.set_y <= set_q[1];
      out_q.set_z <= set_q[2];
    end
  end

endmodule

[design/tag_tracking_pd_controller.sv]
// ----------------------------------------------------------------------------
// Tag tracking PD controller
// Per-tick PD position controller steering a vehicle over a landing tag.
// ----------------------------------------------------------------------------
// One item is taken per control tick. While searching, an item gives no
// result; the first item with the tag seen latches the tag and switches to
// landing. While landing, an item runs from acceptance through the error
// load, per-axis products and setpoints to the result registered at the
// output, and the next item is accepted once back in idle. The single
// shared 33x27 multiplier forms four products per axis (kd*rate, kp*err,
// derivative, vel*rate) over three axes. A finished result waits in its own
// output register, so the next item is taken while it is still pending.
// Configuration writes are registered and must only be issued when idle.
module tag_tracking_pd_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ttpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ttpd_pkg::CfgDataW-1:0] cfg_data_i,
  ttpd_stream_if.sink                   in_i,
  ttpd_stream_if.source                 out_o
);

  `include "assert_macros.svh"

  ttpd_pkg::cmd_t      cmd;
  ttpd_pkg::status_t   status;
  ttpd_pkg::out_item_t out_item;
  logic                in_ready;
  logic                out_valid;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid;
  assign out_o.payload = out_item;

  ttpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ttpd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_i.payload),
    .out_item_o (out_item),
    .cmd_i      (cmd),
    .status_o   (status)
  );

  `ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_valid || out_o.ready)
  `ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid)
  `ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_ready, !in_ready)
  `ASSERT_ALWAYS(a_one_write, $onehot0({cmd.wr_kr, cmd.wr_vel, cmd.wr_acc, cmd.wr_set, cmd.load_out}))

endmodule
